>>> rtl/core/kms_pkg.sv
// shared widths and the job descriptor passed from the load front end to the dp engine
package kms_pkg;

  localparam int IN_W  = 16;
  localparam int OUT_W = 23;
  localparam int NW    = 11;
  localparam int KW    = 7;

  typedef struct packed {
    logic          two_col;
    logic [NW-1:0] n;
    logic [KW-1:0] k;
  } kms_job_t;

endpackage

>>> rtl/core/kms_ram.sv
// generic single write port, single read port ram with registered read data
module kms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/kms_fifo.sv
// two-entry queue used for jobs and for results
module kms_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rdata   = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

>>> rtl/core/kms_front.sv
// load front end: takes rows, builds prefix sums, issues a job after the final row
module kms_front #(
  parameter int ROWS_MAX = 128,
  parameter int K_MAX    = 16,
  parameter int RW       = 7,
  parameter int DW       = 26
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic signed [kms_pkg::IN_W-1:0] col_a_value,
  input  logic signed [kms_pkg::IN_W-1:0] col_b_value,
  input  logic [7:0]                      row_count,
  input  logic                            two_columns,
  input  logic [4:0]                      rect_count,
  input  logic                            hold,
  output logic                            pre_we,
  output logic [RW-1:0]                   pre_addr,
  output logic [DW-1:0]                   pa_wdata,
  output logic [DW-1:0]                   pb_wdata,
  output logic                            job_push,
  output kms_pkg::kms_job_t               job
);
  import kms_pkg::*;

  logic [RW:0]           rows_loaded;
  logic signed [DW-1:0]  sum_a;
  logic signed [DW-1:0]  sum_b;
  logic signed [DW-1:0]  sum_a_next;
  logic signed [DW-1:0]  sum_b_next;
  logic [NW-1:0]         rc_ext;
  logic [NW-1:0]         n_eff;
  logic [NW-1:0]         r_ext;
  logic                  accept;
  logic                  trigger;

  assign full   = hold;
  assign accept = push && !hold;

  always_comb begin
    sum_a_next = ((rows_loaded == '0) ? '0 : sum_a) + DW'(col_a_value);
    sum_b_next = ((rows_loaded == '0) ? '0 : sum_b) + DW'(col_b_value);
    rc_ext = NW'(row_count);
    if (rc_ext == '0) begin
      n_eff = NW'(1);
    end else if (rc_ext > NW'(ROWS_MAX)) begin
      n_eff = NW'(ROWS_MAX);
    end else begin
      n_eff = rc_ext;
    end
    r_ext   = NW'(rows_loaded) + NW'(1);
    trigger = (r_ext >= n_eff);
  end

  assign pre_we      = accept;
  assign pre_addr    = rows_loaded[RW-1:0];
  assign pa_wdata    = sum_a_next;
  assign pb_wdata    = sum_b_next;
  assign job_push    = accept && trigger;
  assign job.two_col = two_columns;
  assign job.n       = r_ext;
  assign job.k       = (KW'(rect_count) > KW'(K_MAX)) ? KW'(K_MAX) : KW'(rect_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_loaded <= '0;
    end else if (accept) begin
      rows_loaded <= trigger ? '0 : rows_loaded + (RW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sum_a <= sum_a_next;
      sum_b <= sum_b_next;
    end
  end

endmodule

>>> rtl/core/kms_back.sv
// dp engine: sweeps layers, rows and cells with running maxima, each cell in states S_CELLA and S_CELLB
module kms_back #(
  parameter int ROWS_MAX = 128,
  parameter int K_MAX    = 16,
  parameter int RW       = 7,
  parameter int DW       = 26
) (
  input  logic                             clk,
  input  logic                             rst,
  input  kms_pkg::kms_job_t                job,
  input  logic                             job_empty,
  output logic                             job_pop,
  input  logic                             res_full,
  output logic                             res_push,
  output logic [kms_pkg::OUT_W-1:0]        res_data,
  output logic                             busy,
  output logic [RW-1:0]                    pa_raddr,
  input  logic signed [DW-1:0]             pa_rdata,
  output logic [RW-1:0]                    pb_raddr,
  input  logic signed [DW-1:0]             pb_rdata
);
  import kms_pkg::*;

  localparam int TW = $clog2(K_MAX + 1);
  localparam int AW = 2 * RW;
  localparam int LD = 1 << AW;
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROW   = 3'd1;
  localparam logic [2:0] S_ROWLD = 3'd2;
  localparam logic [2:0] S_CELLA = 3'd3;
  localparam logic [2:0] S_CELLB = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;
  localparam logic signed [DW-1:0] SAT = DW'(23'h7fffff);

  function automatic logic signed [DW-1:0] smax(input logic signed [DW-1:0] x,
                                                input logic signed [DW-1:0] y);
    return (x > y) ? x : y;
  endfunction

  logic [2:0]           state;
  logic                 two_col;
  logic                 sel;
  logic [RW:0]          n;
  logic [RW:0]          i;
  logic [RW:0]          j;
  logic [TW-1:0]        k;
  logic [TW-1:0]        t;
  logic signed [DW-1:0] pa_i;
  logic signed [DW-1:0] pa_prev;
  logic signed [DW-1:0] colp_prev;
  logic signed [DW-1:0] mb;
  logic signed [DW-1:0] md;
  logic signed [DW-1:0] left_best;
  logic signed [DW-1:0] best_reg;

  logic [RW:0]          im1;
  logic [RW:0]          im2;
  logic [RW:0]          jm1;
  logic [RW:0]          jm2;
  logic [AW-1:0]        addr_up;
  logic [AW-1:0]        addr_left;
  logic [AW-1:0]        addr_cell;
  logic                 cell_write;
  logic signed [DW-1:0] m0a_rd;
  logic signed [DW-1:0] m0b_rd;
  logic signed [DW-1:0] m1a_rd;
  logic signed [DW-1:0] m1b_rd;
  logic signed [DW-1:0] ma_rd;

  logic                 first_layer;
  logic signed [DW-1:0] colp;
  logic signed [DW-1:0] cur_up;
  logic signed [DW-1:0] prv_up;
  logic signed [DW-1:0] prv_left;
  logic signed [DW-1:0] v_left;
  logic signed [DW-1:0] v_up_prv;
  logic signed [DW-1:0] v_up_cur;
  logic signed [DW-1:0] mb_n;
  logic signed [DW-1:0] ma_n;
  logic signed [DW-1:0] md_n;
  logic signed [DW-1:0] term_a;
  logic signed [DW-1:0] term_b;
  logic signed [DW-1:0] diag;
  logic signed [DW-1:0] cand;
  logic                 md_upd;

  assign im1       = i - (RW+1)'(1);
  assign im2       = i - (RW+1)'(2);
  assign jm1       = j - (RW+1)'(1);
  assign jm2       = j - (RW+1)'(2);
  assign addr_up   = {im2[RW-1:0], jm1[RW-1:0]};
  assign addr_left = {im1[RW-1:0], jm2[RW-1:0]};
  assign addr_cell = {im1[RW-1:0], jm1[RW-1:0]};
  assign cell_write = (state == S_CELLB);

  assign pa_raddr = (state == S_ROW) ? im1[RW-1:0] : jm1[RW-1:0];
  assign pb_raddr = jm1[RW-1:0];

  kms_ram #(.WIDTH(DW), .DEPTH(LD)) u_l0a (
    .clk(clk), .we(cell_write && !sel), .waddr(addr_cell), .wdata(cand),
    .raddr(addr_up), .rdata(m0a_rd)
  );
  kms_ram #(.WIDTH(DW), .DEPTH(LD)) u_l0b (
    .clk(clk), .we(cell_write && !sel), .waddr(addr_cell), .wdata(cand),
    .raddr(addr_left), .rdata(m0b_rd)
  );
  kms_ram #(.WIDTH(DW), .DEPTH(LD)) u_l1a (
    .clk(clk), .we(cell_write && sel), .waddr(addr_cell), .wdata(cand),
    .raddr(addr_up), .rdata(m1a_rd)
  );
  kms_ram #(.WIDTH(DW), .DEPTH(LD)) u_l1b (
    .clk(clk), .we(cell_write && sel), .waddr(addr_cell), .wdata(cand),
    .raddr(addr_left), .rdata(m1b_rd)
  );
  kms_ram #(.WIDTH(DW), .DEPTH(ROWS_MAX)) u_colmax (
    .clk(clk), .we(cell_write), .waddr(jm1[RW-1:0]), .wdata(ma_n),
    .raddr(jm1[RW-1:0]), .rdata(ma_rd)
  );

  always_comb begin
    first_layer = (t == TW'(1));
    colp     = two_col ? pb_rdata : pa_rdata;
    cur_up   = sel ? m1a_rd : m0a_rd;
    prv_up   = sel ? m0a_rd : m1a_rd;
    prv_left = sel ? m0b_rd : m1b_rd;
    v_left   = ((j == (RW+1)'(1)) || first_layer) ? '0 : prv_left;
    v_up_prv = ((i == (RW+1)'(1)) || first_layer) ? '0 : prv_up;
    v_up_cur = (i == (RW+1)'(1)) ? '0 : cur_up;
    mb_n     = (j == (RW+1)'(1)) ? '0 : smax(mb, v_left - colp_prev);
    ma_n     = (i == (RW+1)'(1)) ? '0 : smax(ma_rd, v_up_prv - pa_prev);
    md_n     = smax(md, v_up_prv - pa_prev - colp);
    md_upd   = two_col && (j == im1);
    term_b   = mb_n + colp;
    term_a   = ma_n + pa_i;
    diag     = md + pa_i + colp;
    cand     = smax(smax(left_best, v_up_cur), term_b);
    if (two_col) begin
      cand = smax(cand, term_a);
      if (i == j) begin
        cand = smax(cand, diag);
      end
    end
  end

  assign job_pop  = (state == S_IDLE) && !job_empty;
  assign res_push = (state == S_DONE) && !res_full;
  assign busy     = (state != S_IDLE);

  always_comb begin
    if (best_reg < 0) begin
      res_data = '0;
    end else if (best_reg > SAT) begin
      res_data = SAT[OUT_W-1:0];
    end else begin
      res_data = best_reg[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!job_empty) begin
            two_col  <= job.two_col;
            n        <= job.n[RW:0];
            k        <= job.k[TW-1:0];
            t        <= TW'(1);
            sel      <= 1'b0;
            i        <= (RW+1)'(1);
            md       <= '0;
            best_reg <= '0;
            state    <= (job.k == '0) ? S_DONE : S_ROW;
          end
        end
        S_ROW: begin
          pa_prev   <= (i == (RW+1)'(1)) ? '0 : pa_i;
          j         <= (RW+1)'(1);
          left_best <= '0;
          colp_prev <= '0;
          state     <= S_ROWLD;
        end
        S_ROWLD: begin
          pa_i  <= pa_rdata;
          state <= S_CELLA;
        end
        S_CELLA: begin
          state <= S_CELLB;
        end
        S_CELLB: begin
          left_best <= cand;
          colp_prev <= colp;
          mb        <= mb_n;
          best_reg  <= cand;
          if (md_upd) begin
            md <= md_n;
          end
          if (j == n) begin
            if (two_col && (i != n)) begin
              i     <= i + (RW+1)'(1);
              state <= S_ROW;
            end else if (t == k) begin
              state <= S_DONE;
            end else begin
              t     <= t + TW'(1);
              sel   <= ~sel;
              i     <= (RW+1)'(1);
              md    <= '0;
              state <= S_ROW;
            end
          end else begin
            j     <= j + (RW+1)'(1);
            state <= S_CELLA;
          end
        end
        S_DONE: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/k_max_sum_rectangles_dp.sv
// top level: config registers, prefix memories, load front end, job queue, dp engine
// flow: a row is taken in the cycle it is pushed unless held; the last row issues a job
// to the dp engine, which sweeps k layers of n cells (one-column) or n*n cells (two-column),
// states S_CELLA and S_CELLB per cell on the layer memories, then pushes the result
// throughput: one job at a time; rows are refused while a job is queued or computing
// reset: synchronous, clears counters, queues and engine state and loads the config defaults; memories are not cleared
module k_max_sum_rectangles_dp #(
  parameter int ROWS_MAX = 128,
  parameter int K_MAX    = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic signed [kms_pkg::IN_W-1:0] col_a_value,
  input  logic signed [kms_pkg::IN_W-1:0] col_b_value,
  output logic                            empty,
  input  logic                            pop,
  output logic [kms_pkg::OUT_W-1:0]       best_sum,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [3:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import kms_pkg::*;

  localparam int RW = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
  localparam int DW = (RW + 19 > 25) ? RW + 19 : 25;
  localparam logic [1:0] REG_ROW_COUNT   = 2'd0;
  localparam logic [1:0] REG_TWO_COLUMNS = 2'd1;
  localparam logic [1:0] REG_RECT_COUNT  = 2'd2;

  logic [7:0]           row_count;
  logic                 two_columns;
  logic [4:0]           rect_count;
  logic                 hold;
  logic                 pre_we;
  logic [RW-1:0]        pre_addr;
  logic [DW-1:0]        pa_wdata;
  logic [DW-1:0]        pb_wdata;
  logic                 job_push;
  kms_job_t             job_in;
  kms_job_t             job_out;
  logic                 job_full;
  logic                 job_empty;
  logic                 job_pop;
  logic                 res_full;
  logic                 res_push;
  logic [OUT_W-1:0]     res_data;
  logic                 busy;
  logic [RW-1:0]        pa_raddr;
  logic [RW-1:0]        pb_raddr;
  logic signed [DW-1:0] pa_rdata;
  logic signed [DW-1:0] pb_rdata;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= 8'd1;
      two_columns <= 1'b0;
      rect_count  <= 5'd1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_ROW_COUNT:   row_count   <= pwdata[7:0];
        REG_TWO_COLUMNS: two_columns <= pwdata[0];
        REG_RECT_COUNT:  rect_count  <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ROW_COUNT:   prdata = 32'(row_count);
      REG_TWO_COLUMNS: prdata = 32'(two_columns);
      REG_RECT_COUNT:  prdata = 32'(rect_count);
      default:         prdata = '0;
    endcase
  end

  assign hold = !job_empty || busy || job_full;

  kms_front #(.ROWS_MAX(ROWS_MAX), .K_MAX(K_MAX), .RW(RW), .DW(DW)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .col_a_value(col_a_value), .col_b_value(col_b_value),
    .row_count(row_count), .two_columns(two_columns), .rect_count(rect_count),
    .hold(hold), .pre_we(pre_we), .pre_addr(pre_addr),
    .pa_wdata(pa_wdata), .pb_wdata(pb_wdata), .job_push(job_push), .job(job_in)
  );

  kms_ram #(.WIDTH(DW), .DEPTH(ROWS_MAX)) u_prefix_a (
    .clk(clk), .we(pre_we), .waddr(pre_addr), .wdata(pa_wdata),
    .raddr(pa_raddr), .rdata(pa_rdata)
  );

  kms_ram #(.WIDTH(DW), .DEPTH(ROWS_MAX)) u_prefix_b (
    .clk(clk), .we(pre_we), .waddr(pre_addr), .wdata(pb_wdata),
    .raddr(pb_raddr), .rdata(pb_rdata)
  );

  kms_fifo #(.WIDTH($bits(kms_job_t))) u_job_q (
    .clk(clk), .rst(rst), .push(job_push), .wdata(job_in), .full(job_full),
    .pop(job_pop), .rdata(job_out), .empty(job_empty)
  );

  kms_back #(.ROWS_MAX(ROWS_MAX), .K_MAX(K_MAX), .RW(RW), .DW(DW)) u_back (
    .clk(clk), .rst(rst), .job(job_out), .job_empty(job_empty), .job_pop(job_pop),
    .res_full(res_full), .res_push(res_push), .res_data(res_data), .busy(busy),
    .pa_raddr(pa_raddr), .pa_rdata(pa_rdata), .pb_raddr(pb_raddr), .pb_rdata(pb_rdata)
  );

  kms_fifo #(.WIDTH(OUT_W)) u_res_q (
    .clk(clk), .rst(rst), .push(res_push), .wdata(res_data),
    .full(res_full), .pop(pop), .rdata(best_sum), .empty(empty)
  );

endmodule

>>> rtl/core/kms_checker.sv
// port-level checker for the top level and its bind
module kms_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      full,
  input logic                      empty,
  input logic                      pop,
  input logic [kms_pkg::OUT_W-1:0] best_sum
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_reset_open: assert property (@(posedge clk) rst |=> !full)
    else $error("input side blocked after reset");

  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> !full)
    else $error("input still blocked when a result transfer became available");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(best_sum))
    else $error("waiting result changed before its transfer");

endmodule

bind k_max_sum_rectangles_dp kms_checker u_kms_checker (.*);

>>> tb/tb_k_max_sum_rectangles_dp.sv
// testbench for k_max_sum_rectangles_dp: directed and random row loads checked against a dp predictor
module tb_k_max_sum_rectangles_dp;
  timeunit 1ns;
  timeprecision 1ps;

  import kms_pkg::*;

  localparam logic [3:0] REG_ROW_COUNT  = 4'd0;
  localparam logic [3:0] REG_TWO_COLS   = 4'd4;
  localparam logic [3:0] REG_RECT_COUNT = 4'd8;
  localparam int ROWS_MAX    = 128;
  localparam int K_MAX       = 16;
  localparam int SUM_MAX     = 23'h7FFFFF;
  localparam int CYCLE_LIMIT = 2000000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  logic signed [IN_W-1:0] col_a_value = '0;
  logic signed [IN_W-1:0] col_b_value = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [OUT_W-1:0]       best_sum;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [3:0]             paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;

  k_max_sum_rectangles_dp dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .col_a_value(col_a_value), .col_b_value(col_b_value),
    .empty(empty), .pop(pop), .best_sum(best_sum),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [7:0]       row_count_reg;
  logic             two_cols_reg;
  logic [4:0]       rect_count_reg;
  int               prefix_a [0:ROWS_MAX];
  int               prefix_b [0:ROWS_MAX];
  int               layer_cur [0:ROWS_MAX][0:ROWS_MAX];
  int               layer_prv [0:ROWS_MAX][0:ROWS_MAX];
  int               rows_loaded;
  logic [OUT_W-1:0] expected_sums[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int cycles = 0;

  initial forever #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer: best_sum %0d", best_sum);
      end else begin
        logic [OUT_W-1:0] want;
        want = expected_sums.pop_front();
        if (best_sum !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("best_sum mismatch: expected %0d actual %0d", want, best_sum);
        end
      end
    end
    pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic int max2(int x, int y);
    return x > y ? x : y;
  endfunction

  function int best_total(int n, int k);
    int best;
    for (int i = 0; i <= n; i++)
      for (int j = 0; j <= n; j++) begin
        layer_cur[i][j] = 0;
        layer_prv[i][j] = 0;
      end
    if (k == 0) return 0;
    for (int t = 1; t <= k; t++) begin
      if (!two_cols_reg) begin
        layer_cur[0][0] = 0;
        for (int i = 1; i <= n; i++) begin
          best = layer_cur[0][i-1];
          for (int l = 1; l <= i; l++)
            best = max2(best, layer_prv[0][l-1] + prefix_a[i] - prefix_a[l-1]);
          layer_cur[0][i] = best;
        end
      end else begin
        for (int i = 0; i <= n; i++)
          for (int j = 0; j <= n; j++) begin
            if (i == 0 || j == 0) begin
              layer_cur[i][j] = 0;
            end else begin
              best = max2(layer_cur[i][j-1], layer_cur[i-1][j]);
              for (int l = 1; l <= i; l++)
                best = max2(best, layer_prv[l-1][j] + prefix_a[i] - prefix_a[l-1]);
              for (int l = 1; l <= j; l++)
                best = max2(best, layer_prv[i][l-1] + prefix_b[j] - prefix_b[l-1]);
              if (i == j)
                for (int l = 1; l <= i; l++)
                  best = max2(best, layer_prv[l-1][l-1] + prefix_a[i] - prefix_a[l-1]
                                    + prefix_b[j] - prefix_b[l-1]);
              layer_cur[i][j] = best;
            end
          end
      end
      for (int i = 0; i <= n; i++)
        for (int j = 0; j <= n; j++) layer_prv[i][j] = layer_cur[i][j];
    end
    return two_cols_reg ? layer_cur[n][n] : layer_cur[0][n];
  endfunction

  task automatic predict_row(logic signed [IN_W-1:0] a, logic signed [IN_W-1:0] b);
    int n_eff, k_eff, best;
    n_eff = (row_count_reg == 0) ? 1 : int'(row_count_reg);
    if (n_eff > ROWS_MAX) n_eff = ROWS_MAX;
    k_eff = (rect_count_reg > K_MAX) ? K_MAX : int'(rect_count_reg);
    if (rows_loaded >= ROWS_MAX) rows_loaded = ROWS_MAX - 1;
    prefix_a[0] = 0;
    prefix_b[0] = 0;
    prefix_a[rows_loaded+1] = prefix_a[rows_loaded] + int'(a);
    prefix_b[rows_loaded+1] = prefix_b[rows_loaded] + int'(b);
    rows_loaded++;
    if (rows_loaded < n_eff) return;
    best = best_total(rows_loaded, k_eff);
    rows_loaded = 0;
    if (best < 0) best = 0;
    if (best > SUM_MAX) best = SUM_MAX;
    expected_sums.push_back(best[OUT_W-1:0]);
  endtask

  task automatic send_row(logic signed [IN_W-1:0] a, logic signed [IN_W-1:0] b);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    push <= 1'b1;
    col_a_value <= a;
    col_b_value <= b;
    do @(posedge clk); while (full);
    predict_row(a, b);
  endtask

  // stop sending, wait for every result, then let the engine settle
  task automatic drain();
    push <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] addr, logic [31:0] value);
    push <= 1'b0;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      REG_ROW_COUNT:  row_count_reg = value[7:0];
      REG_TWO_COLS:   two_cols_reg = value[0];
      REG_RECT_COUNT: rect_count_reg = value[4:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_job(int rows, int two, int rects);
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_TWO_COLS, two);
    write_reg(REG_RECT_COUNT, rects);
  endtask

  function automatic logic signed [IN_W-1:0] rand_value();
    case ($urandom_range(0, 3))
      0: return 16'($urandom());
      1: return $signed(16'($urandom_range(0, 100))) - 16'sd50;
      2: return 16'($urandom_range(0, 32767));
      default: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  task automatic test_defaults();
    send_row(16'sh7FFF, 16'sh8000);
    send_row(16'sh8000, 16'sh7FFF);
    send_row(-16'sd1, 16'sd0);
    drain();
  endtask

  task automatic test_one_column();
    set_job(4, 0, 2);
    send_row(16'sh7FFF, 16'sh7FFF);
    send_row(16'sh8000, 16'sh1234);
    send_row(16'sd5, -16'sd9);
    send_row(16'sh7FFF, 16'sh8000);
    drain();
  endtask

  task automatic test_two_columns();
    set_job(3, 1, 2);
    send_row(16'sh7FFF, 16'sh8000);
    send_row(-16'sd3, 16'sh7FFF);
    send_row(16'sh7FFF, 16'sh7FFF);
    drain();
  endtask

  task automatic test_rect_limits();
    set_job(2, 1, 0);
    send_row(16'sd100, 16'sd200);
    send_row(16'sd7, -16'sd1);
    drain();
    set_job(6, 1, 31);
    for (int i = 0; i < 6; i++) send_row(i[0] ? 16'sh7FFF : 16'sh8000, i[0] ? 16'sh8000 : 16'sh7FFF);
    drain();
  endtask

  task automatic test_row_limits();
    set_job(0, 0, 1);
    send_row(16'sd42, 16'sd0);
    drain();
    set_job(255, 0, 31);
    for (int i = 0; i < ROWS_MAX; i++) send_row(16'sh7FFF, 16'sh7FFF);
    drain();
  endtask

  task automatic test_mid_load_changes();
    set_job(6, 0, 3);
    send_row(16'sd10, 16'sd1);
    send_row(-16'sd20, 16'sd2);
    send_row(16'sd30, 16'sd3);
    drain();
    write_reg(REG_ROW_COUNT, 2);
    send_row(16'sd40, 16'sd4);
    drain();
    set_job(5, 0, 2);
    send_row(16'sd5, 16'sd500);
    send_row(-16'sd6, -16'sd600);
    drain();
    write_reg(REG_TWO_COLS, 1);
    for (int i = 0; i < 3; i++) send_row(rand_value(), rand_value());
    drain();
  endtask

  task automatic test_random(int s_pct, int r_pct, int item_goal);
    int sent, rows, two, rects, sel;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < item_goal) begin
      two = $urandom_range(0, 1);
      sel = $urandom_range(0, 39);
      if (sel == 0) rows = 0;
      else if (sel == 1 && !two) rows = $urandom_range(129, 255);
      else if (sel < 6 && !two) rows = $urandom_range(9, 40);
      else rows = $urandom_range(1, two ? 7 : 10);
      rects = $urandom_range(0, 31);
      set_job(rows, two, rects);
      if ($urandom_range(0, 9) == 0 && rows > 2) begin
        // partial load, then shrink the row count to one or set two-column mode
        send_row(rand_value(), rand_value());
        sent++;
        drain();
        if ($urandom_range(0, 1)) write_reg(REG_ROW_COUNT, 1);
        else write_reg(REG_TWO_COLS, 1);
      end
      do begin
        send_row(rand_value(), rand_value());
        sent++;
      end while (rows_loaded != 0);
      drain();
    end
  endtask

  initial begin
    row_count_reg = 8'd1;
    two_cols_reg = 1'b0;
    rect_count_reg = 5'd1;
    rows_loaded = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_one_column();
    test_two_columns();
    test_rect_limits();
    test_row_limits();
    test_mid_load_changes();
    test_random(29, 85, 100);
    test_random(85, 29, 100);
    test_random(0, 0, 100);
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_sums.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
